// ===== rtl/core/fat_chain_allocator_core_defines.svh =====
// Shared assertion macros for the allocator core
`ifndef FAT_CHAIN_ALLOCATOR_CORE_DEFINES_SVH
`define FAT_CHAIN_ALLOCATOR_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define FCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Check that cons holds in the cycle after ante
`define FCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/core/fca_pkg.sv =====
package fca_pkg;

  localparam int TABLE_ENTRIES  = 4096;
  localparam int DIR_SLOTS      = 128;
  localparam int RESERVED_PAGES = 40;

  localparam int PAGE_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_W = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int LINK_W = 16;
  localparam int COUNT_W = 12;

  localparam logic [LINK_W-1:0] END_MARK   = 16'hFFFF;
  localparam logic [LINK_W:0]   TE_LINK    = (LINK_W + 1)'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0]  TE_CNT     = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0]  TE_CNT_M1  = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  RES_CNT    = CNT_W'(RESERVED_PAGES);
  localparam logic [PAGE_W-1:0] LAST_PAGE  = PAGE_W'(TABLE_ENTRIES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(DIR_SLOTS - 1);

  typedef enum logic [1:0] {
    K_CREATE = 2'd0,
    K_DELETE = 2'd1,
    K_EXTEND = 2'd2,
    K_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DIR_FULL  = 2'd2,
    ST_NO_PAGES  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SLOT_SCAN, S_FREE_RD, S_FREE_CHK, S_DIR_RD, S_DIR_WAIT,
    S_LINK_RD, S_LINK_CHK, S_EXT_LOOP, S_EXT_END, S_QRY_RD, S_QRY_CHK, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLR, OP_SLOT_NEXT, OP_FREE_RD, OP_FREE_SKIP,
    OP_CREATE_WR, OP_NOPAGE, OP_DIRFULL, OP_NOTFOUND, OP_DIR_RD, OP_LOAD_P,
    OP_LINK_RD, OP_DEL_WR, OP_WALK_ADV, OP_EXT_WR, OP_EXT_END, OP_QRY_RD,
    OP_QRY_OUT, OP_PUBLISH
  } op_t;

  // Status flags from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic slot_used;
    logic slot_last;
    logic slot_hit;
    logic scan_end;
    logic rd_zero;
    logic link_valid;
    logic steps_lt;
    logic steps_lt1;
    logic count_zero;
  } dp_stat_t;

endpackage

// ===== rtl/core/fca_ram.sv =====
module fca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fca_datapath.sv =====
module fca_datapath import fca_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  op_t                 op,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [COUNT_W-1:0]  in_count,
  input  logic [PAGE_W-1:0]   in_pidx,
  input  kind_t               in_kind,
  output dp_stat_t            stat,
  output logic [1:0]          res_status,
  output logic [SLOT_W-1:0]   res_slot,
  output logic [LINK_W-1:0]   res_page
);

  // Working registers
  kind_t              kind;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] count;
  logic [PAGE_W-1:0]  pidx;
  logic [PAGE_W-1:0]  p;
  logic [CNT_W-1:0]   scan;
  logic [CNT_W-1:0]   steps;
  logic [SLOT_W-1:0]  slot_cnt;
  logic [PAGE_W-1:0]  clr_cnt;
  status_t            status;
  logic [SLOT_W-1:0]  slot_out;
  logic [LINK_W-1:0]  page_out;
  logic [DIR_SLOTS-1:0] used;

  // Memory ports
  logic              link_we, link_re, dir_we, dir_re;
  logic [PAGE_W-1:0] link_waddr, link_raddr;
  logic [LINK_W-1:0] link_wdata, link_rdata;
  logic [PAGE_W-1:0] dir_rdata;

  fca_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_ENTRIES)) u_link (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
  );

  fca_ram #(.WIDTH(PAGE_W), .DEPTH(DIR_SLOTS)) u_dir (
    .clk, .we(dir_we), .waddr(slot_cnt), .wdata(scan[PAGE_W-1:0]),
    .re(dir_re), .raddr(slot), .rdata(dir_rdata)
  );

  // Link table and directory port selection
  always_comb begin
    link_we    = 1'b0;
    link_re    = 1'b0;
    link_waddr = p;
    link_raddr = p;
    link_wdata = '0;
    dir_we     = 1'b0;
    dir_re     = 1'b0;
    case (op)
      OP_CLR: begin
        link_we    = 1'b1;
        link_waddr = clr_cnt;
        link_wdata = ({1'b0, clr_cnt} < RES_CNT) ? END_MARK : '0;
      end
      OP_FREE_RD: begin
        link_re    = 1'b1;
        link_raddr = scan[PAGE_W-1:0];
      end
      OP_CREATE_WR: begin
        link_we    = 1'b1;
        link_waddr = scan[PAGE_W-1:0];
        link_wdata = END_MARK;
        dir_we     = 1'b1;
      end
      OP_DIR_RD:  dir_re = 1'b1;
      OP_LINK_RD: link_re = 1'b1;
      OP_DEL_WR:  link_we = 1'b1;
      OP_EXT_WR: begin
        link_we    = 1'b1;
        link_wdata = LINK_W'(scan);
      end
      OP_EXT_END: begin
        link_we    = 1'b1;
        link_wdata = END_MARK;
      end
      OP_QRY_RD: begin
        link_re    = 1'b1;
        link_raddr = pidx;
      end
      default: ;
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.clr_last   = (clr_cnt == LAST_PAGE);
    stat.slot_used  = used[slot_cnt];
    stat.slot_last  = (slot_cnt == LAST_SLOT);
    stat.slot_hit   = used[slot];
    stat.scan_end   = (scan >= TE_CNT);
    stat.rd_zero    = (link_rdata == '0);
    stat.link_valid = (link_rdata != END_MARK) && (link_rdata != '0) &&
                      ({1'b0, link_rdata} < TE_LINK);
    stat.steps_lt   = (steps < TE_CNT);
    stat.steps_lt1  = (steps < TE_CNT_M1);
    stat.count_zero = (count == '0);
  end

  // Control-like registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      used    <= '0;
    end else begin
      case (op)
        OP_CLR:       clr_cnt <= clr_cnt + 1'b1;
        OP_CREATE_WR: used[slot_cnt] <= 1'b1;
        OP_DIR_RD:    if (kind == K_DELETE) used[slot] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Working registers per operation
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        kind     <= in_kind;
        slot     <= in_slot;
        count    <= in_count;
        pidx     <= in_pidx;
        scan     <= CNT_W'(1);
        steps    <= '0;
        slot_cnt <= '0;
        status   <= ST_OK;
        slot_out <= '0;
        page_out <= END_MARK;
      end
      OP_SLOT_NEXT: slot_cnt <= slot_cnt + 1'b1;
      OP_FREE_SKIP: scan <= scan + 1'b1;
      OP_CREATE_WR: begin
        slot_out <= slot_cnt;
        page_out <= LINK_W'(scan);
      end
      OP_NOPAGE:   status <= ST_NO_PAGES;
      OP_DIRFULL:  status <= ST_DIR_FULL;
      OP_NOTFOUND: status <= ST_NOT_FOUND;
      OP_LOAD_P:   p <= dir_rdata;
      OP_DEL_WR: begin
        p     <= link_rdata[PAGE_W-1:0];
        steps <= steps + 1'b1;
      end
      OP_WALK_ADV: begin
        p     <= link_rdata[PAGE_W-1:0];
        steps <= steps + 1'b1;
      end
      OP_EXT_WR: begin
        p     <= scan[PAGE_W-1:0];
        scan  <= scan + 1'b1;
        count <= count - 1'b1;
      end
      OP_EXT_END: page_out <= (status == ST_OK) ? LINK_W'(p) : END_MARK;
      OP_QRY_OUT: page_out <= (link_rdata == '0) ? END_MARK : link_rdata;
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (op == OP_PUBLISH) begin
      res_status <= status;
      res_slot   <= slot_out;
      res_page   <= page_out;
    end
  end

endmodule

// ===== rtl/core/fca_ctrl.sv =====
module fca_ctrl import fca_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  kind_t    in_kind,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output op_t      op
);

  state_t state, state_next;
  kind_t  kind;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:     if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            K_CREATE: state_next = S_SLOT_SCAN;
            K_QUERY:  state_next = S_QRY_RD;
            default:  state_next = S_DIR_RD;
          endcase
        end
      end
      S_SLOT_SCAN: begin
        if (!stat.slot_used) state_next = S_FREE_RD;
        else if (stat.slot_last) state_next = S_FIN;
      end
      S_FREE_RD: begin
        if (stat.scan_end) state_next = (kind == K_CREATE) ? S_FIN : S_EXT_END;
        else state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (stat.rd_zero) state_next = (kind == K_CREATE) ? S_FIN : S_EXT_LOOP;
        else state_next = S_FREE_RD;
      end
      S_DIR_RD:   state_next = stat.slot_hit ? S_DIR_WAIT : S_FIN;
      S_DIR_WAIT: state_next = S_LINK_RD;
      S_LINK_RD:  state_next = S_LINK_CHK;
      S_LINK_CHK: begin
        if (kind == K_DELETE) begin
          state_next = (stat.link_valid && stat.steps_lt1) ? S_LINK_RD : S_FIN;
        end else begin
          state_next = (stat.link_valid && stat.steps_lt) ? S_LINK_RD : S_EXT_LOOP;
        end
      end
      S_EXT_LOOP: state_next = stat.count_zero ? S_EXT_END : S_FREE_RD;
      S_EXT_END:  state_next = S_FIN;
      S_QRY_RD:   state_next = S_QRY_CHK;
      S_QRY_CHK:  state_next = S_FIN;
      S_FIN:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Datapath command
  always_comb begin
    op = OP_NONE;
    case (state)
      S_CLEAR:     op = OP_CLR;
      S_IDLE:      if (in_valid) op = OP_LOAD;
      S_SLOT_SCAN: begin
        if (stat.slot_used) op = stat.slot_last ? OP_DIRFULL : OP_SLOT_NEXT;
      end
      S_FREE_RD:   op = stat.scan_end ? OP_NOPAGE : OP_FREE_RD;
      S_FREE_CHK: begin
        if (!stat.rd_zero) op = OP_FREE_SKIP;
        else op = (kind == K_CREATE) ? OP_CREATE_WR : OP_EXT_WR;
      end
      S_DIR_RD:    op = stat.slot_hit ? OP_DIR_RD : OP_NOTFOUND;
      S_DIR_WAIT:  op = OP_LOAD_P;
      S_LINK_RD:   op = OP_LINK_RD;
      S_LINK_CHK: begin
        if (kind == K_DELETE) op = OP_DEL_WR;
        else if (stat.link_valid && stat.steps_lt) op = OP_WALK_ADV;
      end
      S_EXT_END:   op = OP_EXT_END;
      S_QRY_RD:    op = OP_QRY_RD;
      S_QRY_CHK:   op = OP_QRY_OUT;
      S_FIN:       if (out_free) op = OP_PUBLISH;
      default:     op = OP_NONE;
    endcase
  end

  // State, request kind and output word flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      kind      <= K_CREATE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) kind <= in_kind;
      if (op == OP_PUBLISH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/fat_chain_allocator_core.sv =====
// Page-chain allocator with a file directory. After reset the block
// formats all TABLE_ENTRIES entries of the link table and does not take
// requests meanwhile. Each request then runs on a controller that steps
// through link-table accesses one at a time, each entry read registered:
// a query reads one entry, delete frees each chain page in turn, create
// scans the directory for a free slot and then the pages for the first
// free page, and extend walks to the chain end and then appends pages,
// each at the first free page scanning upward from page 1. One request
// is in work at a time; a finished result waits in an output register
// while the next request is taken.
`include "fat_chain_allocator_core_defines.svh"

module fat_chain_allocator_core import fca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // file_slot[6:0], page_count[18:7], page_index[30:19]
  input  logic [1:0]  s_tuser,  // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // status[1:0], slot_out[8:2], page_out[24:9]
);

  op_t               op;
  dp_stat_t          stat;
  kind_t             in_kind;
  logic [1:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [LINK_W-1:0] res_page;

  assign in_kind = kind_t'(s_tuser);

  fca_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_kind,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .stat, .op
  );

  fca_datapath u_dp (
    .clk, .rst, .op,
    .in_slot(s_tdata[6:0]), .in_count(s_tdata[18:7]), .in_pidx(s_tdata[30:19]),
    .in_kind, .stat, .res_status, .res_slot, .res_page
  );

  // Pack the result word
  assign m_tdata = {7'd0, res_page, res_slot, res_status};

  // An accepted word starts work, so the input closes for the next cycle
  `FCA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // The table is being formatted right after reset
  `FCA_ASSERT_NOW(a_no_accept_in_format, $past(rst), !s_tready && !m_tvalid)

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import fca_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [6:0]  slot;
    logic [15:0] page;
  } alloc_result_t;

  // Mirror of the allocator state plus the queue of results still owed
  class alloc_scoreboard;
    logic [15:0]   links [TABLE_ENTRIES];
    logic [15:0]   starts [DIR_SLOTS];
    alloc_result_t owed [$];
    int            errors;
    int            checked;
    int            per_status [4];

    function void format();
      for (int i = 0; i < TABLE_ENTRIES; i++)
        links[i] = (i < RESERVED_PAGES) ? END_MARK : 16'h0000;
      for (int i = 0; i < DIR_SLOTS; i++)
        starts[i] = 16'h0000;
    endfunction

    // First-fit search; page 0 is never handed out
    function int first_free(int from);
      if (from < 1) from = 1;
      for (int p = from; p < TABLE_ENTRIES; p++)
        if (links[p] == 16'h0000) return p;
      return 0;
    endfunction

    // Follow one link; 0 when the chain ends here
    function int follow(int p);
      logic [15:0] v;
      v = links[p];
      if (v == END_MARK || v == 16'h0000 || v >= TABLE_ENTRIES) return 0;
      return v;
    endfunction

    function void note_request(kind_t k, int slot, int cnt, int pidx);
      alloc_result_t r;
      int s, pg, start, p, nx, steps, scan;
      r.status = ST_OK;
      r.slot = '0;
      r.page = END_MARK;
      case (k)
        K_CREATE: begin
          for (s = 0; s < DIR_SLOTS; s++)
            if (starts[s] == 16'h0000) break;
          if (s >= DIR_SLOTS) begin
            r.status = ST_DIR_FULL;
          end else begin
            pg = first_free(1);
            if (pg == 0) begin
              r.status = ST_NO_PAGES;
            end else begin
              links[pg] = END_MARK;
              starts[s] = 16'(pg);
              r.slot = 7'(s);
              r.page = 16'(pg);
            end
          end
        end
        K_DELETE, K_EXTEND: begin
          start = starts[slot];
          if (start == 0 || start >= TABLE_ENTRIES) begin
            r.status = ST_NOT_FOUND;
          end else if (k == K_DELETE) begin
            // Free the whole chain, capped at one pass over the table
            starts[slot] = 16'h0000;
            p = start;
            steps = 0;
            do begin
              nx = follow(p);
              links[p] = 16'h0000;
              p = nx;
              steps++;
            end while (nx != 0 && steps < TABLE_ENTRIES);
          end else begin
            // Walk to the chain end, then append first-fit pages
            p = start;
            steps = 0;
            scan = 1;
            while (steps < TABLE_ENTRIES && follow(p) != 0) begin
              p = follow(p);
              steps++;
            end
            while (cnt > 0) begin
              pg = first_free(scan);
              if (pg == 0) begin
                r.status = ST_NO_PAGES;
                break;
              end
              links[pg] = END_MARK;
              links[p] = 16'(pg);
              p = pg;
              scan = pg + 1;
              cnt--;
            end
            links[p] = END_MARK;
            if (r.status == ST_OK) r.page = 16'(p);
          end
        end
        default: begin
          if (pidx < TABLE_ENTRIES)
            r.page = (links[pidx] == 16'h0000) ? END_MARK : links[pidx];
        end
      endcase
      owed.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch: %s got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] d);
      alloc_result_t want;
      if (owed.size() == 0) begin
        report("unexpected word", d, 0);
        return;
      end
      want = owed.pop_front();
      checked++;
      per_status[want.status]++;
      if (d[1:0] != want.status) report("status", d[1:0], want.status);
      if (d[8:2] != want.slot) report("slot_out", d[8:2], want.slot);
      if (d[24:9] != want.page) report("page_out", d[24:9], want.page);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  alloc_scoreboard sb = new();
  bit quiet;
  bit hold_request;
  int stall_left;

  fat_chain_allocator_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none while quiet
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word and hold it until accepted
  task send(kind_t k, int slot, int cnt, int pidx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {1'b0, 12'(pidx), 12'(cnt), 7'(slot)};
    do @(posedge clk); while (!s_tready);
    sb.note_request(k, slot, cnt, pidx);
  endtask

  // Prefer a slot that holds a file
  function int pick_used_slot();
    int off;
    off = $urandom_range(0, DIR_SLOTS - 1);
    for (int j = 0; j < DIR_SLOTS; j++)
      if (sb.starts[(off + j) % DIR_SLOTS] != 16'h0000) return (off + j) % DIR_SLOTS;
    return off;
  endfunction

  task send_mixed();
    int r, c, s;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : pick_used_slot();
    if (r < 25) begin
      send(K_CREATE, $urandom_range(0, 127), $urandom_range(0, 4095), $urandom_range(0, 4095));
    end else if (r < 45) begin
      send(K_DELETE, s, $urandom_range(0, 4095), $urandom_range(0, 4095));
    end else if (r < 72) begin
      c = $urandom_range(0, 99);
      if (c < 86) c = $urandom_range(0, 12);
      else if (c < 98) c = $urandom_range(13, 200);
      else c = 4095;
      send(K_EXTEND, s, c, $urandom_range(0, 4095));
    end else begin
      c = ($urandom_range(0, 1) == 0) ? sb.starts[pick_used_slot()] : $urandom_range(0, 4095);
      send(K_QUERY, $urandom_range(0, 127), $urandom_range(0, 4095), c);
    end
  endtask

  // Check each result and pace the receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 300;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #1_000_000_000;
    $display("fat_chain_allocator_core regression: fail");
    $finish;
  end

  initial begin
    sb.format();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = K_CREATE;
    m_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reserved area, empty slots, first files, full table
    send(K_QUERY, 127, 4095, 0);
    send(K_QUERY, 0, 0, 39);
    send(K_QUERY, 0, 0, 40);
    send(K_QUERY, 0, 0, 4095);
    send(K_DELETE, 5, 0, 0);
    send(K_EXTEND, 127, 4095, 0);
    send(K_CREATE, 0, 0, 0);
    send(K_CREATE, 127, 4095, 4095);
    send(K_EXTEND, 0, 0, 0);
    send(K_EXTEND, 0, 3, 0);
    send(K_QUERY, 0, 0, 40);
    send(K_DELETE, 1, 0, 0);
    send(K_QUERY, 0, 0, 41);
    send(K_EXTEND, 0, 4095, 0);
    send(K_CREATE, 0, 0, 0);
    send(K_QUERY, 0, 0, 4095);
    send(K_DELETE, 0, 0, 0);
    send(K_QUERY, 0, 0, 4095);
    send(K_CREATE, 0, 0, 0);

    // Random traffic, with a quiet stretch
    for (int i = 0; i < 240; i++) begin
      quiet = (i >= 100 && i < 140);
      send_mixed();
    end
    quiet = 1'b0;

    // Fill the directory past its end
    for (int i = 0; i < 132; i++)
      send(K_CREATE, $urandom_range(0, 127), $urandom_range(0, 4095), $urandom_range(0, 4095));

    // Long receiver hold while requests keep coming
    hold_request = 1'b1;
    for (int i = 0; i < 240; i++) begin
      if (i % 3 == 0)
        send(K_DELETE, pick_used_slot(), $urandom_range(0, 4095), $urandom_range(0, 4095));
      else
        send_mixed();
    end
    s_tvalid <= 1'b0;

    // Drain
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d results: ok %0d, not found %0d, directory full %0d, no pages %0d",
      sb.checked, sb.per_status[ST_OK], sb.per_status[ST_NOT_FOUND],
      sb.per_status[ST_DIR_FULL], sb.per_status[ST_NO_PAGES]);
    if (sb.errors == 0)
      $display("fat_chain_allocator_core regression: pass");
    else
      $display("fat_chain_allocator_core regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fca_pkg.sv
rtl/core/fca_ram.sv
rtl/core/fca_datapath.sv
rtl/core/fca_ctrl.sv
rtl/core/fat_chain_allocator_core.sv
bench/tb_top.sv
